// ----- rtl/core/ffha_pkg.sv -----
// ---------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes for the first-fit heap allocator.
// ---------------------------------------------------------------------------
package ffha_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_KICK  = 2'd2,
        CMD_INIT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_BADFREE = 2'd2
    } status_t;

    localparam logic [15:0] MAGIC_RESET = 16'hA5A5;
    localparam int unsigned LEN_W = 15;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT0,
        S_INIT1,
        S_INIT2,
        S_INIT3,
        S_FREE_RD,
        S_FREE_WT,
        S_FREE_CHK,
        S_AL_START,
        S_AL_RD,
        S_AL_WT,
        S_AL_EVAL,
        S_AL_PRD,
        S_AL_PWT,
        S_AL_MERGE,
        S_AL_NRD,
        S_AL_NWT,
        S_AL_NCHK,
        S_AL_SPLIT,
        S_AL_MARK,
        S_KICK_FREE,
        S_OUT
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;        // capture input item
        logic init_wr;     // write init header (index in init_step)
        logic [1:0] init_step;
        logic free_rd;     // read header at free word
        logic free_wr;     // write freed header
        logic al_start;    // set walk start word
        logic rd_cur;      // read header at cur
        logic take_cur;    // latch cur header
        logic mark_prev;   // prev <= cur, coal <= 1
        logic clr_coal;
        logic rd_prev;
        logic merge_wr;    // write merged prev length
        logic rd_next;     // read header at next word
        logic step;        // cur <= next
        logic split_wr;
        logic mark_wr;
        logic kick_wr;
        logic fail;
        logic set_ok;
        logic set_bad;
        logic set_kicked;
    } ctl_t;

    typedef struct packed {
        logic is_small;
        logic start_oob;
        logic cur_used;
        logic coal;
        logic fit_cur;
        logic fit_merged;
        logic len_zero;
        logic next_oob;
        logic next_zero;
        logic free_pre_bad;
        logic free_bad;
        logic kick_mode;
    } sts_t;

endpackage

// ----- rtl/core/ffha_ctrl.sv -----
// ---------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for init, free, kick and the first-fit walk of alloc.
// ---------------------------------------------------------------------------
module ffha_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  ffha_pkg::cmd_t  cmd,
    input  logic            out_busy,
    output logic            idle,
    output logic            out_load,
    input  ffha_pkg::sts_t  sts,
    output ffha_pkg::ctl_t  ctl
);
    import ffha_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (cmd)
                        CMD_INIT: state_next = S_INIT0;
                        CMD_FREE: state_next = S_FREE_RD;
                        default:  state_next = S_AL_START;
                    endcase
                end
            end
            S_INIT0:    state_next = S_INIT1;
            S_INIT1:    state_next = S_INIT2;
            S_INIT2:    state_next = S_INIT3;
            S_INIT3:    state_next = S_OUT;
            S_FREE_RD:  state_next = sts.free_pre_bad ? S_OUT : S_FREE_WT;
            S_FREE_WT:  state_next = S_FREE_CHK;
            S_FREE_CHK: state_next = S_OUT;
            S_AL_START: state_next = sts.start_oob ? S_OUT : S_AL_RD;
            S_AL_RD:    state_next = S_AL_WT;
            S_AL_WT:    state_next = S_AL_EVAL;
            S_AL_EVAL:
            begin
                if (sts.cur_used)
                    state_next = S_AL_NRD;
                else if (sts.coal)
                    state_next = S_AL_PRD;
                else if (sts.fit_cur)
                    state_next = S_AL_SPLIT;
                else
                    state_next = S_AL_NRD;
            end
            S_AL_PRD:   state_next = S_AL_PWT;
            S_AL_PWT:   state_next = S_AL_MERGE;
            S_AL_MERGE: state_next = sts.fit_merged ? S_AL_SPLIT : S_AL_NRD;
            S_AL_NRD:   state_next = (sts.len_zero || sts.next_oob) ? S_OUT : S_AL_NWT;
            S_AL_NWT:   state_next = S_AL_NCHK;
            S_AL_NCHK:  state_next = sts.next_zero ? S_OUT : S_AL_RD;
            S_AL_SPLIT: state_next = S_AL_MARK;
            S_AL_MARK:  state_next = sts.kick_mode ? S_KICK_FREE : S_OUT;
            S_KICK_FREE: state_next = S_OUT;
            S_OUT:      state_next = out_busy ? S_OUT : S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        out_load = 1'b0;
        idle = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: ctl.load = in_fire;
            S_INIT0: begin ctl.init_wr = 1'b1; ctl.init_step = 2'd0; end
            S_INIT1: begin ctl.init_wr = 1'b1; ctl.init_step = 2'd1; end
            S_INIT2: begin ctl.init_wr = 1'b1; ctl.init_step = 2'd2; end
            S_INIT3:
            begin
                ctl.init_wr = 1'b1;
                ctl.init_step = 2'd3;
                ctl.set_ok = 1'b1;
            end
            S_FREE_RD:
            begin
                if (sts.free_pre_bad)
                    ctl.set_bad = 1'b1;
                else
                    ctl.free_rd = 1'b1;
            end
            S_FREE_CHK:
            begin
                if (sts.free_bad)
                    ctl.set_bad = 1'b1;
                else
                begin
                    ctl.free_wr = 1'b1;
                    ctl.set_ok = 1'b1;
                end
            end
            S_AL_START:
            begin
                ctl.al_start = 1'b1;
                if (sts.start_oob)
                    ctl.fail = 1'b1;
            end
            S_AL_RD: ctl.rd_cur = 1'b1;
            S_AL_EVAL:
            begin
                ctl.take_cur = 1'b1;
                if (sts.cur_used)
                    ctl.clr_coal = 1'b1;
                else if (!sts.coal && !sts.fit_cur)
                    ctl.mark_prev = 1'b1;
            end
            S_AL_PRD: ctl.rd_prev = 1'b1;
            S_AL_MERGE: ctl.merge_wr = 1'b1;
            S_AL_NRD:
            begin
                if (sts.len_zero || sts.next_oob)
                    ctl.fail = 1'b1;
                else
                    ctl.rd_next = 1'b1;
            end
            S_AL_NCHK:
            begin
                if (sts.next_zero)
                    ctl.fail = 1'b1;
                else
                    ctl.step = 1'b1;
            end
            S_AL_SPLIT: ctl.split_wr = 1'b1;
            S_AL_MARK:
            begin
                ctl.mark_wr = 1'b1;
                ctl.set_ok = 1'b1;
            end
            S_KICK_FREE: ctl.kick_wr = 1'b1;
            S_OUT: out_load = !out_busy;
            default: ;
        endcase
        if (state_reg == S_OUT && !out_busy && sts.kick_mode)
            ctl.set_kicked = 1'b1;
    end

endmodule

// ----- rtl/core/ffha_dp.sv -----
// ---------------------------------------------------------------------------
// ffha_dp
// Header memory, walk pointers and result registers.
// ---------------------------------------------------------------------------
module ffha_dp #(
    parameter int HEAP_BYTES         = 4096,
    parameter int SMALL_BLOCK_BYTES  = 16,
    parameter int SMALL_BUCKET_BYTES = 752,
    parameter int MIN_SPLIT_BYTES    = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ffha_pkg::ctl_t    ctl,
    output ffha_pkg::sts_t    sts,
    input  logic [1:0]        in_cmd,
    input  logic [14:0]       in_req,
    input  logic [11:0]       in_addr,
    input  logic [15:0]       magic,
    output logic [1:0]        res_status,
    output logic [11:0]       res_data,
    output logic [11:0]       res_granted
);
    import ffha_pkg::*;

    localparam int WORDS  = HEAP_BYTES / 4;
    localparam int AW     = $clog2(WORDS);
    localparam int BUCKW  = SMALL_BUCKET_BYTES / 4;
    localparam logic [16:0] BIG =
        (BUCKW + 2 < WORDS) ? 17'((WORDS - BUCKW - 2) * 4) : 17'd0;

    logic [31:0] mem [WORDS];
    logic [31:0] rdata_reg;

    logic            we;
    logic [AW-1:0]   waddr;
    logic [31:0]     wdata;
    logic            re;
    logic [AW-1:0]   raddr;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    logic [1:0]   cmd_reg;
    logic [15:0]  size_reg;
    logic [12:0]  fw_reg;         // free header word, wide enough for range check
    logic [11:0]  in_addr_reg;
    logic [16:0]  cur_reg, prev_reg, nxt_reg;
    logic [31:0]  cur_h_reg;
    logic         coal_reg;
    logic [AW-1:0] ffw_reg;
    logic         kicked_reg;
    logic [1:0]   status_reg;
    logic [AW-1:0] hit_reg;
    logic [14:0]  hitlen_reg;
    logic         hit_ok_reg;

    logic [15:0] size_c;
    assign size_c = (16'(in_req) + 16'd7) & 16'hFFFC;

    logic [14:0] cur_len, prev_len, merged;
    assign cur_len  = rdata_reg[14:0];
    assign prev_len = rdata_reg[14:0];
    assign merged   = prev_len + cur_h_reg[14:0];

    logic [16:0] nxt_c;
    assign nxt_c = cur_reg + 17'(cur_h_reg[14:2]);

    logic [16:0] start_c;
    assign start_c = (size_reg <= 16'(SMALL_BLOCK_BYTES)) ? 17'(ffw_reg) : 17'(BUCKW + 1);

    // Header of the hit block, with the live length of the hit entry.
    logic [14:0] hl;
    logic [15:0] rem;
    logic        do_split;
    assign rem = 16'(hitlen_reg) - size_reg;
    assign do_split = (16'(hitlen_reg) >= size_reg) && (rem >= 16'(MIN_SPLIT_BYTES));
    assign hl = do_split ? size_reg[14:0] : hitlen_reg;
    logic [16:0] split_w;
    assign split_w = 17'(hit_reg) + 17'(size_reg[15:2]);

    always_comb
    begin
        sts = '0;
        sts.start_oob = start_c >= 17'(WORDS);
        sts.cur_used  = rdata_reg[15];
        sts.coal      = coal_reg;
        sts.fit_cur   = 16'(cur_len) >= size_reg;
        sts.fit_merged = 16'(merged) >= size_reg;
        sts.len_zero  = cur_h_reg[14:2] == 13'd0;
        sts.next_oob  = nxt_c >= 17'(WORDS);
        sts.next_zero = rdata_reg == 32'd0;
        sts.free_pre_bad = (in_addr_reg[1:0] != 2'd0) || (in_addr_reg < 12'd4) ||
                           (fw_reg >= 13'(WORDS));
        sts.free_bad  = !rdata_reg[15] || (rdata_reg[31:16] != magic);
        sts.kick_mode = cmd_reg == CMD_KICK;
        sts.is_small  = size_reg <= 16'(SMALL_BLOCK_BYTES);
    end

    always_comb
    begin
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        re = 1'b0;
        raddr = '0;
        if (ctl.init_wr)
        begin
            case (ctl.init_step)
                2'd0:
                begin
                    we = 1'b1; waddr = AW'(WORDS - 1); wdata = '0;
                end
                2'd1:
                begin
                    we = 1'b1; waddr = '0;
                    wdata = {17'd0, 15'(SMALL_BUCKET_BYTES)};
                end
                2'd2:
                begin
                    we = (BUCKW < WORDS); waddr = AW'(BUCKW);
                    wdata = {magic, 1'b1, 15'd4};
                end
                default:
                begin
                    we = (BUCKW + 1 < WORDS); waddr = AW'(BUCKW + 1);
                    wdata = {17'd0, BIG[14:0]};
                end
            endcase
        end
        if (ctl.free_rd)
        begin
            re = 1'b1; raddr = fw_reg[AW-1:0];
        end
        if (ctl.free_wr)
        begin
            we = 1'b1; waddr = fw_reg[AW-1:0];
            wdata = {magic, 1'b0, rdata_reg[14:0]};
        end
        if (ctl.rd_cur)
        begin
            re = 1'b1; raddr = cur_reg[AW-1:0];
        end
        if (ctl.rd_prev)
        begin
            re = 1'b1; raddr = prev_reg[AW-1:0];
        end
        if (ctl.merge_wr)
        begin
            we = 1'b1; waddr = prev_reg[AW-1:0];
            wdata = {rdata_reg[31:15], merged};
        end
        if (ctl.rd_next)
        begin
            re = 1'b1; raddr = nxt_c[AW-1:0];
        end
        if (ctl.split_wr)
        begin
            we = do_split && (split_w < 17'(WORDS));
            waddr = split_w[AW-1:0];
            wdata = {16'd0, rem};
        end
        if (ctl.mark_wr)
        begin
            we = 1'b1; waddr = hit_reg; wdata = {magic, 1'b1, hl};
        end
        if (ctl.kick_wr)
        begin
            we = 1'b1; waddr = hit_reg; wdata = {magic, 1'b0, hitlen_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ffw_reg    <= '0;
            kicked_reg <= 1'b0;
            coal_reg   <= 1'b0;
            status_reg <= ST_OK;
            hit_ok_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load)
            begin
                coal_reg   <= 1'b0;
                hit_ok_reg <= 1'b0;
                status_reg <= ST_OOM;
            end
            if (ctl.init_wr && ctl.init_step == 2'd3)
                ffw_reg <= '0;
            if (ctl.free_wr && 13'(ffw_reg) > fw_reg)
                ffw_reg <= fw_reg[AW-1:0];
            if (ctl.mark_prev)
                coal_reg <= 1'b1;
            if (ctl.clr_coal)
                coal_reg <= 1'b0;
            if (ctl.set_bad)
                status_reg <= ST_BADFREE;
            if (ctl.fail)
                status_reg <= (cmd_reg == CMD_KICK) ? ST_OK : ST_OOM;
            if (ctl.set_ok)
                status_reg <= ST_OK;
            if (ctl.mark_wr)
            begin
                hit_ok_reg <= (cmd_reg == CMD_ALLOC);
                if (kicked_reg && ffw_reg == hit_reg)
                    ffw_reg <= hit_reg + AW'(hl[14:2]);
            end
            if (ctl.kick_wr)
                ffw_reg <= hit_reg;
            if (ctl.set_kicked)
                kicked_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg     <= in_cmd;
            size_reg    <= (in_cmd == CMD_KICK) ? 16'd8 : size_c;
            in_addr_reg <= in_addr;
            fw_reg      <= 13'(in_addr[11:2]) - 13'd1;
        end
        if (ctl.al_start)
            cur_reg <= start_c;
        if (ctl.take_cur)
        begin
            cur_h_reg <= rdata_reg;
            if (!rdata_reg[15] && !coal_reg && 16'(cur_len) >= size_reg)
            begin
                hit_reg    <= cur_reg[AW-1:0];
                hitlen_reg <= cur_len;
            end
            if (!rdata_reg[15] && !coal_reg)
                prev_reg <= cur_reg;
        end
        if (ctl.merge_wr)
        begin
            hit_reg    <= prev_reg[AW-1:0];
            hitlen_reg <= merged;
        end
        if (ctl.mark_wr)
            hitlen_reg <= hl;
        if (ctl.rd_next)
            nxt_reg <= nxt_c;
        if (ctl.step)
            cur_reg <= nxt_reg;
    end

    assign res_status  = status_reg;
    assign res_data    = hit_ok_reg ? 12'({hit_reg, 2'b00} + 14'd4) : 12'd0;
    assign res_granted = hit_ok_reg ? hitlen_reg[11:0] : 12'd0;

endmodule

// ----- rtl/core/first_fit_heap_allocator.sv -----
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with free-block coalescing on a header memory.
// ---------------------------------------------------------------------------
// One command is worked at a time, and every header goes through the single
// read port of the header memory. Init writes the initial headers. A free reads
// the header in front of the block, unless the address is rejected, and writes
// it back freed when its check passes. An alloc or a kick reads and tests every
// block header it visits, reads the free neighbor's header and writes the merged
// length when the block is merged into it, and reads the next header when the
// walk moves on. The result then waits in the output register until taken; the
// next command is accepted from the cycle after the result is loaded.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES         = 4096,
    parameter int SMALL_BLOCK_BYTES  = 16,
    parameter int SMALL_BUCKET_BYTES = 752,
    parameter int MIN_SPLIT_BYTES    = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // request_bytes[14:0], free_address[26:15]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // data_address[11:0], granted_bytes[23:12]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // magic word
);
    import ffha_pkg::*;

    logic [15:0] magic_reg;
    logic        idle, out_load, in_fire;
    ctl_t        ctl;
    sts_t        sts;
    logic [1:0]  r_status;
    logic [11:0] r_data, r_granted;
    logic [25:0] out_reg;
    logic        mv_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            magic_reg <= MAGIC_RESET;
        else if (cfg_valid)
            magic_reg <= cfg_data;
    end

    assign s_tready = idle;
    assign in_fire  = s_tvalid && s_tready;

    ffha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .cmd      (cmd_t'(s_tuser)),
        .out_busy (mv_reg && !m_tready),
        .idle     (idle),
        .out_load (out_load),
        .sts      (sts),
        .ctl      (ctl)
    );

    ffha_dp #(
        .HEAP_BYTES         (HEAP_BYTES),
        .SMALL_BLOCK_BYTES  (SMALL_BLOCK_BYTES),
        .SMALL_BUCKET_BYTES (SMALL_BUCKET_BYTES),
        .MIN_SPLIT_BYTES    (MIN_SPLIT_BYTES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .in_cmd      (s_tuser),
        .in_req      (s_tdata[14:0]),
        .in_addr     (s_tdata[26:15]),
        .magic       (magic_reg),
        .res_status  (r_status),
        .res_data    (r_data),
        .res_granted (r_granted)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mv_reg <= 1'b0;
        else if (out_load)
            mv_reg <= 1'b1;
        else if (m_tready)
            mv_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= {r_granted, r_data, r_status};
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = out_reg[25:2];
    assign m_tuser  = out_reg[1:0];

    ap_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid) else $error("result not presented");
    ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> idle) else $error("accept while busy");
    ap_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= ST_BADFREE)) else $error("bad status code");

endmodule
